// ===== sv/gpu_block_resource_tracker_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the GPU block resource tracker
// Concurrent property checks; compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef GPU_BLOCK_RESOURCE_TRACKER_CORE_MACROS_SVH
`define GPU_BLOCK_RESOURCE_TRACKER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define GBRT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define GBRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GBRT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define GBRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/gbrt_pkg.sv =====
// ----------------------------------------------------------------------------
// GPU block resource tracker package
// Field widths, item types, codes and shared arithmetic helpers.
// ----------------------------------------------------------------------------
package gbrt_pkg;

  localparam int unsigned REGS_W     = 24;
  localparam int unsigned SMEM_W     = 28;
  localparam int unsigned THR_W      = 20;
  localparam int unsigned BLK_W      = 16;
  localparam int unsigned CFG_DATA_W = 28;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned RPT_W  = 8;
  localparam int unsigned TPB_W  = 11;
  localparam int unsigned SPB_W  = 19;
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned FIT_W  = 16;
  localparam int unsigned DOT_W  = 44;
  localparam int unsigned OCC_W  = 17;
  localparam int unsigned RBLK_W = 19;

  localparam int unsigned MUL_A_W = 28;
  localparam int unsigned MUL_B_W = 19;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned AMT_W   = 31;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned DVD_W   = 44;
  localparam int unsigned DVS_W   = 28;
  localparam int unsigned QUO_W   = 18;
  localparam int unsigned DIV_STEPS = QUO_W / 2;
  localparam int unsigned STEP_W  = 4;

  localparam logic [REGS_W-1:0] TOTAL_REGS_RST = 24'd65536;
  localparam logic [SMEM_W-1:0] TOTAL_SMEM_RST = 28'd65536;
  localparam logic [THR_W-1:0]  TOTAL_THR_RST  = 20'd2048;
  localparam logic [BLK_W-1:0]  TOTAL_BLK_RST  = 16'd32;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [RPT_W-1:0] regs_per_thread;
    logic [TPB_W-1:0] threads_per_block;
    logic [SPB_W-1:0] smem_per_block;
    logic [CNT_W-1:0] block_count;
  } gbrt_in_t;

  typedef struct packed {
    logic [FIT_W-1:0] fit_blocks;
    logic [DOT_W-1:0] dot_score;
    logic [OCC_W-1:0] occupancy;
  } gbrt_out_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_QUERY   = 2'd2
  } gbrt_act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_REGS    = 2'd0,
    CFG_TOTAL_SMEM    = 2'd1,
    CFG_TOTAL_THREADS = 2'd2,
    CFG_TOTAL_BLOCKS  = 2'd3
  } gbrt_cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REGBLK,
    S_DEM0,
    S_DEM1,
    S_DEM2,
    S_DEM3,
    S_DOT1,
    S_DOT2,
    S_DOT3,
    S_DIVLD,
    S_DIVRUN,
    S_DIVFOLD,
    S_DONE
  } gbrt_state_e;

  typedef enum logic [2:0] {
    JOB_FIT_REG,
    JOB_FIT_THR,
    JOB_FIT_SMEM,
    JOB_OCC_THR,
    JOB_OCC_SMEM,
    JOB_OCC_REG
  } gbrt_job_e;

  typedef struct packed {
    logic [DVS_W-1:0] rem;
    logic             qbit;
  } gbrt_dstep_t;

  // acquire saturates at zero, release saturates at the total
  function automatic logic [SMEM_W-1:0] upd_free(gbrt_act_e act,
                                                 logic [SMEM_W-1:0] free_c,
                                                 logic [AMT_W-1:0] amt,
                                                 logic [SMEM_W-1:0] cap);
    logic [AMT_W:0]    sum;
    logic [SMEM_W-1:0] res;
    sum = (AMT_W+1)'(free_c) + (AMT_W+1)'(amt);
    case (act)
      ACT_ACQUIRE: begin
        res = (AMT_W'(free_c) <= amt) ? '0 : free_c - amt[SMEM_W-1:0];
      end
      ACT_RELEASE: begin
        res = (sum > (AMT_W+1)'(cap)) ? cap : sum[SMEM_W-1:0];
      end
      default: begin
        res = free_c;
      end
    endcase
    return res;
  endfunction

  // one restoring division step
  function automatic gbrt_dstep_t div_step(logic [DVS_W-1:0] rem,
                                           logic din,
                                           logic [DVS_W-1:0] dvs);
    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    gbrt_dstep_t    r;
    trial = {rem, din};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      r.qbit = 1'b1;
      r.rem  = diff[DVS_W-1:0];
    end else begin
      r.qbit = 1'b0;
      r.rem  = trial[DVS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/gbrt_if.sv =====
// ----------------------------------------------------------------------------
// GPU block resource tracker channels
// Valid/ready channels carrying one job item in and one result item out.
// ----------------------------------------------------------------------------
interface gbrt_in_if;
  logic                valid;
  logic                ready;
  gbrt_pkg::gbrt_in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gbrt_out_if;
  logic                valid;
  logic                ready;
  gbrt_pkg::gbrt_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/gpu_block_resource_tracker_core.sv =====
// ----------------------------------------------------------------------------
// GPU block resource tracker: after accept it runs the multiply/update states
// REGBLK, DEM0-DEM3 and DOT1-DOT3, six divider jobs (each skipped, or loaded,
// run and folded) and a result state, on one shared 28x19 multiplier and a
// 2-bit divider. One item at a time; output stalls hold off the next item.
// Async active-low reset loads the default totals and full free counts.
// ----------------------------------------------------------------------------
`include "gpu_block_resource_tracker_core_macros.svh"

module gpu_block_resource_tracker_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gbrt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gbrt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  gbrt_in_if.sink                         in_i,
  gbrt_out_if.source                      out_o
);

  import gbrt_pkg::*;

  gbrt_state_e state_q, state_d;
  gbrt_job_e   job_q;

  logic [REGS_W-1:0] total_regs_q, free_regs_q;
  logic [SMEM_W-1:0] total_smem_q, free_smem_q;
  logic [THR_W-1:0]  total_thr_q,  free_thr_q;
  logic [BLK_W-1:0]  total_blk_q,  free_blk_q;

  logic [ACT_W-1:0]  act_q;
  logic [RPT_W-1:0]  rpt_q;
  logic [TPB_W-1:0]  tpb_q;
  logic [SPB_W-1:0]  spb_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [RBLK_W-1:0]  rblk_q;
  logic [MUL_P_W-1:0] prod_q;
  logic [ACC_W-1:0]   acc_q;
  logic [FIT_W-1:0]   fit_q;
  logic [OCC_W-1:0]   occ_q;

  logic [DVS_W-1:0]  rem_q, dvs_q;
  logic [QUO_W-1:0]  dvd_q, quo_q;
  logic [STEP_W-1:0] step_q;

  logic      out_valid_q;
  gbrt_out_t out_data_q;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  logic [SMEM_W-1:0] upd_in, upd_cap, upd_res;
  logic [AMT_W-1:0]  upd_amt;

  logic             ld_skip, ld_ovf;
  logic [DVD_W-1:0] ld_dvd;
  logic [DVS_W-1:0] ld_dvs;
  gbrt_dstep_t      ds1, ds2;

  logic             in_fire, out_fire, out_room, last_job, fit_job;
  logic [DOT_W-1:0] dot_sat;
  logic             free_ok, div_run;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_valid_q & out_o.ready;
  assign out_room = !out_valid_q || out_o.ready;
  assign last_job = (job_q == JOB_OCC_REG);
  assign fit_job  = job_q inside {JOB_FIT_REG, JOB_FIT_THR, JOB_FIT_SMEM};
  assign dot_sat  = (acc_q[ACC_W-1:DOT_W] != '0) ? '1 : acc_q[DOT_W-1:0];
  assign free_ok  = (free_regs_q <= total_regs_q) && (free_smem_q <= total_smem_q) &&
                    (free_thr_q <= total_thr_q) && (free_blk_q <= total_blk_q);
  assign div_run  = (state_q == S_DIVRUN);

  // shared multiplier
  always_comb begin
    case (state_q)
      S_REGBLK: begin mul_a = MUL_A_W'(tpb_q);       mul_b = MUL_B_W'(rpt_q);  end
      S_DEM0:   begin mul_a = MUL_A_W'(rblk_q);      mul_b = MUL_B_W'(cnt_q);  end
      S_DEM1:   begin mul_a = MUL_A_W'(tpb_q);       mul_b = MUL_B_W'(cnt_q);  end
      S_DEM2:   begin mul_a = MUL_A_W'(spb_q);       mul_b = MUL_B_W'(cnt_q);  end
      S_DEM3:   begin mul_a = MUL_A_W'(free_regs_q); mul_b = MUL_B_W'(rblk_q); end
      S_DOT1:   begin mul_a = MUL_A_W'(free_thr_q);  mul_b = MUL_B_W'(tpb_q);  end
      S_DOT2:   begin mul_a = free_smem_q;           mul_b = MUL_B_W'(spb_q);  end
      default:  begin mul_a = '0;                    mul_b = '0;               end
    endcase
    mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  // shared free-count update unit
  always_comb begin
    case (state_q)
      S_DEM0: begin
        upd_in = SMEM_W'(free_blk_q); upd_amt = AMT_W'(cnt_q); upd_cap = SMEM_W'(total_blk_q);
      end
      S_DEM1: begin
        upd_in = SMEM_W'(free_regs_q); upd_amt = prod_q[AMT_W-1:0];
        upd_cap = SMEM_W'(total_regs_q);
      end
      S_DEM2: begin
        upd_in = SMEM_W'(free_thr_q); upd_amt = prod_q[AMT_W-1:0];
        upd_cap = SMEM_W'(total_thr_q);
      end
      S_DEM3: begin
        upd_in = free_smem_q; upd_amt = prod_q[AMT_W-1:0]; upd_cap = total_smem_q;
      end
      default: begin
        upd_in = '0; upd_amt = '0; upd_cap = '0;
      end
    endcase
    upd_res = upd_free(gbrt_act_e'(act_q), upd_in, upd_amt, upd_cap);
  end

  // divider job setup
  always_comb begin
    case (job_q)
      JOB_FIT_REG: begin
        ld_skip = (free_blk_q == '0) || (tpb_q == '0) || (rblk_q == '0);
        ld_dvd  = DVD_W'(free_regs_q);
        ld_dvs  = DVS_W'(rblk_q);
      end
      JOB_FIT_THR: begin
        ld_skip = (free_blk_q == '0) || (tpb_q == '0);
        ld_dvd  = DVD_W'(free_thr_q);
        ld_dvs  = DVS_W'(tpb_q);
      end
      JOB_FIT_SMEM: begin
        ld_skip = (free_blk_q == '0) || (spb_q == '0);
        ld_dvd  = DVD_W'(free_smem_q);
        ld_dvs  = DVS_W'(spb_q);
      end
      JOB_OCC_THR: begin
        ld_skip = (total_thr_q == '0) || (free_thr_q >= total_thr_q);
        ld_dvd  = {DVS_W'(total_thr_q - free_thr_q), 16'b0};
        ld_dvs  = DVS_W'(total_thr_q);
      end
      JOB_OCC_SMEM: begin
        ld_skip = (total_smem_q == '0) || (free_smem_q >= total_smem_q);
        ld_dvd  = {total_smem_q - free_smem_q, 16'b0};
        ld_dvs  = total_smem_q;
      end
      JOB_OCC_REG: begin
        ld_skip = (total_regs_q == '0) || (free_regs_q >= total_regs_q);
        ld_dvd  = {DVS_W'(total_regs_q - free_regs_q), 16'b0};
        ld_dvs  = DVS_W'(total_regs_q);
      end
      default: begin
        ld_skip = 1'b1;
        ld_dvd  = '0;
        ld_dvs  = '0;
      end
    endcase
    // quotient too large for the unit: no limit on the fit count
    ld_ovf = DVS_W'(ld_dvd[DVD_W-1:QUO_W]) >= ld_dvs;
  end

  assign ds1 = div_step(rem_q, dvd_q[QUO_W-1], dvs_q);
  assign ds2 = div_step(ds1.rem, dvd_q[QUO_W-2], dvs_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_fire) state_d = S_REGBLK;
      S_REGBLK:  state_d = S_DEM0;
      S_DEM0:    state_d = S_DEM1;
      S_DEM1:    state_d = S_DEM2;
      S_DEM2:    state_d = S_DEM3;
      S_DEM3:    state_d = S_DOT1;
      S_DOT1:    state_d = S_DOT2;
      S_DOT2:    state_d = S_DOT3;
      S_DOT3:    state_d = S_DIVLD;
      S_DIVLD: begin
        if (ld_skip || ld_ovf) begin
          state_d = last_job ? S_DONE : S_DIVLD;
        end else begin
          state_d = S_DIVRUN;
        end
      end
      S_DIVRUN:  if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = S_DIVFOLD;
      S_DIVFOLD: state_d = last_job ? S_DONE : S_DIVLD;
      S_DONE:    if (out_room) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready  = (state_q == S_IDLE);
    out_o.valid = out_valid_q;
    out_o.data  = out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q        <= JOB_FIT_REG;
      total_regs_q <= TOTAL_REGS_RST;
      total_smem_q <= TOTAL_SMEM_RST;
      total_thr_q  <= TOTAL_THR_RST;
      total_blk_q  <= TOTAL_BLK_RST;
      free_regs_q  <= TOTAL_REGS_RST;
      free_smem_q  <= TOTAL_SMEM_RST;
      free_thr_q   <= TOTAL_THR_RST;
      free_blk_q   <= TOTAL_BLK_RST;
      act_q        <= '0;
      rpt_q        <= '0;
      tpb_q        <= '0;
      spb_q        <= '0;
      cnt_q        <= '0;
      rblk_q       <= '0;
      prod_q       <= '0;
      acc_q        <= '0;
      fit_q        <= '0;
      occ_q        <= '0;
      rem_q        <= '0;
      dvs_q        <= '0;
      dvd_q        <= '0;
      quo_q        <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      prod_q <= mul_p;
      if ((state_q == S_DONE) && out_room) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            act_q <= in_i.data.action;
            rpt_q <= in_i.data.regs_per_thread;
            tpb_q <= in_i.data.threads_per_block;
            spb_q <= in_i.data.smem_per_block;
            cnt_q <= in_i.data.block_count;
          end
        end
        S_REGBLK: rblk_q <= mul_p[RBLK_W-1:0];
        S_DEM0:   free_blk_q  <= upd_res[BLK_W-1:0];
        S_DEM1:   free_regs_q <= upd_res[REGS_W-1:0];
        S_DEM2:   free_thr_q  <= upd_res[THR_W-1:0];
        S_DEM3: begin
          free_smem_q <= upd_res;
          fit_q       <= free_blk_q;
          occ_q       <= '0;
        end
        S_DOT1: acc_q <= ACC_W'(prod_q);
        S_DOT2: acc_q <= acc_q + ACC_W'(prod_q);
        S_DOT3: begin
          acc_q <= acc_q + ACC_W'(prod_q);
          job_q <= JOB_FIT_REG;
        end
        S_DIVLD: begin
          if (ld_skip || ld_ovf) begin
            if (!last_job) job_q <= gbrt_job_e'(job_q + 3'd1);
          end else begin
            rem_q  <= DVS_W'(ld_dvd[DVD_W-1:QUO_W]);
            dvs_q  <= ld_dvs;
            dvd_q  <= ld_dvd[QUO_W-1:0];
            quo_q  <= '0;
            step_q <= '0;
          end
        end
        S_DIVRUN: begin
          rem_q  <= ds2.rem;
          quo_q  <= {quo_q[QUO_W-3:0], ds1.qbit, ds2.qbit};
          dvd_q  <= {dvd_q[QUO_W-3:0], 2'b00};
          step_q <= step_q + STEP_W'(1);
        end
        S_DIVFOLD: begin
          if (fit_job) begin
            if (quo_q < QUO_W'(fit_q)) fit_q <= quo_q[FIT_W-1:0];
          end else begin
            if (quo_q > QUO_W'(occ_q)) occ_q <= quo_q[OCC_W-1:0];
          end
          if (!last_job) job_q <= gbrt_job_e'(job_q + 3'd1);
        end
        S_DONE: begin
          if (out_room) begin
            out_data_q.fit_blocks <= fit_q;
            out_data_q.dot_score  <= dot_sat;
            out_data_q.occupancy  <= occ_q;
          end
        end
        default: ;
      endcase

      // write totals only while idle (unchecked); a write reloads the free count
      if (cfg_we_i) begin
        case (gbrt_cfg_e'(cfg_idx_i))
          CFG_TOTAL_REGS: begin
            total_regs_q <= cfg_data_i[REGS_W-1:0];
            free_regs_q  <= cfg_data_i[REGS_W-1:0];
          end
          CFG_TOTAL_SMEM: begin
            total_smem_q <= cfg_data_i[SMEM_W-1:0];
            free_smem_q  <= cfg_data_i[SMEM_W-1:0];
          end
          CFG_TOTAL_THREADS: begin
            total_thr_q <= cfg_data_i[THR_W-1:0];
            free_thr_q  <= cfg_data_i[THR_W-1:0];
          end
          CFG_TOTAL_BLOCKS: begin
            total_blk_q <= cfg_data_i[BLK_W-1:0];
            free_blk_q  <= cfg_data_i[BLK_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  `GBRT_ASSERT_IMPL(a_free_le_total, clk_i, rst_ni, 1'b1, free_ok, "free count above total")
  `GBRT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !in_i.ready, "ready while busy")
  `GBRT_ASSERT_IMPL(a_rem_below_divisor, clk_i, rst_ni, div_run, rem_q < dvs_q, "bad remainder")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GPU block resource tracker testbench
// Sends job items through the valid/ready channels under random bursts,
// receiver stalls and long back-pressure. It keeps its own free counts and
// totals, computes fit, dot score and occupancy for every item, and checks
// each result field in order. Totals are rewritten between phases,
// including zero, minimum and maximum settings.
// ----------------------------------------------------------------------------
module testbench;
  import gbrt_pkg::*;

  localparam int unsigned STUCK_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned PHASE_ITEMS    = 115;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam logic [63:0] DOT_CEIL       = (64'd1 << DOT_W) - 64'd1;
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  gbrt_in_if  in_ch ();
  gbrt_out_if out_ch ();

  logic [REGS_W-1:0] tot_regs, free_regs;
  logic [SMEM_W-1:0] tot_smem, free_smem;
  logic [THR_W-1:0]  tot_thr, free_thr;
  logic [BLK_W-1:0]  tot_blks, free_blks;

  gbrt_out_t   due_reports[$];
  gbrt_in_t    live_jobs[$];
  gbrt_out_t   want;
  int unsigned errors       = 0;
  int unsigned stuck_cycles = 0;
  int unsigned rx_hold      = 0;
  int unsigned hold_reqs    = 0;
  int unsigned hold_seen    = 0;
  int unsigned burst_left   = 0;
  bit          rx_eager     = 1'b0;
  bit          feed_steady  = 1'b0;
  logic [15:0] rx_pattern   = 16'hA5A5;
  logic [5:0]  rx_tick      = '0;

  gpu_block_resource_tracker_core uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] draw_down(logic [63:0] pool, logic [63:0] amt);
    return (amt >= pool) ? 64'd0 : pool - amt;
  endfunction

  function automatic logic [63:0] refill(logic [63:0] pool, logic [63:0] amt,
                                         logic [63:0] cap);
    logic [63:0] sum;
    sum = pool + amt;
    return (sum > cap) ? cap : sum;
  endfunction

  function automatic logic [63:0] busy_share(logic [63:0] left, logic [63:0] total);
    if (total == 0 || left >= total) return 64'd0;
    return ((total - left) << 16) / total;
  endfunction

  // apply one job to the free counts and work out its report
  task automatic account_job(input gbrt_in_t job, output gbrt_out_t res);
    logic [63:0] rpt, tpb, spb, cnt, rblk, fit, dot, occ, share;
    logic [63:0] fr, ft, fs;
    rpt  = 64'(job.regs_per_thread);
    tpb  = 64'(job.threads_per_block);
    spb  = 64'(job.smem_per_block);
    cnt  = 64'(job.block_count);
    rblk = rpt * tpb;
    case (job.action)
      ACT_ACQUIRE: begin
        free_regs = REGS_W'(draw_down(64'(free_regs), rblk * cnt));
        free_thr  = THR_W'(draw_down(64'(free_thr), tpb * cnt));
        free_smem = SMEM_W'(draw_down(64'(free_smem), spb * cnt));
        free_blks = BLK_W'(draw_down(64'(free_blks), cnt));
      end
      ACT_RELEASE: begin
        free_regs = REGS_W'(refill(64'(free_regs), rblk * cnt, 64'(tot_regs)));
        free_thr  = THR_W'(refill(64'(free_thr), tpb * cnt, 64'(tot_thr)));
        free_smem = SMEM_W'(refill(64'(free_smem), spb * cnt, 64'(tot_smem)));
        free_blks = BLK_W'(refill(64'(free_blks), cnt, 64'(tot_blks)));
      end
      default: ;
    endcase
    fr = 64'(free_regs);
    ft = 64'(free_thr);
    fs = 64'(free_smem);

    fit = 64'(free_blks);
    if (fit != 0 && tpb != 0) begin
      if (rblk != 0 && fr / rblk < fit) fit = fr / rblk;
      if (ft / tpb < fit) fit = ft / tpb;
    end
    if (fit != 0 && spb != 0 && fs / spb < fit) fit = fs / spb;

    dot = fr * rblk + ft * tpb + fs * spb;
    if (dot > DOT_CEIL) dot = DOT_CEIL;

    occ = busy_share(ft, 64'(tot_thr));
    share = busy_share(fs, 64'(tot_smem));
    if (share > occ) occ = share;
    share = busy_share(fr, 64'(tot_regs));
    if (share > occ) occ = share;

    res.fit_blocks = fit[FIT_W-1:0];
    res.dot_score  = dot[DOT_W-1:0];
    res.occupancy  = occ[OCC_W-1:0];
  endtask

  function automatic gbrt_in_t make_job(logic [ACT_W-1:0] act, logic [RPT_W-1:0] rpt,
                                        logic [TPB_W-1:0] tpb, logic [SPB_W-1:0] spb,
                                        logic [CNT_W-1:0] cnt);
    gbrt_in_t j;
    j.action            = act;
    j.regs_per_thread   = rpt;
    j.threads_per_block = tpb;
    j.smem_per_block    = spb;
    j.block_count       = cnt;
    return j;
  endfunction

  function automatic gbrt_in_t random_shape();
    gbrt_in_t j;
    j.action = ACT_QUERY;
    case ($urandom_range(0, 5))
      0: j.regs_per_thread = '1;
      1: j.regs_per_thread = '0;
      2: j.regs_per_thread = RPT_W'($urandom);
      default: j.regs_per_thread = RPT_W'($urandom_range(0, 64));
    endcase
    case ($urandom_range(0, 7))
      0: j.threads_per_block = TPB_W'(1024);
      1: j.threads_per_block = '0;
      2: j.threads_per_block = TPB_W'($urandom_range(0, 1024));
      default: j.threads_per_block = TPB_W'(32 * $urandom_range(0, 8));
    endcase
    case ($urandom_range(0, 7))
      0: j.smem_per_block = SPB_W'(262144);
      1: j.smem_per_block = '0;
      2: j.smem_per_block = SPB_W'($urandom_range(0, 262144));
      default: j.smem_per_block = SPB_W'($urandom_range(0, 8192));
    endcase
    case ($urandom_range(0, 7))
      0: j.block_count = CNT_W'($urandom);
      1: j.block_count = '0;
      default: j.block_count = CNT_W'($urandom_range(1, 4));
    endcase
    return j;
  endfunction

  // mostly acquire/release pairs of the same shape, some queries and noise
  function automatic gbrt_in_t next_random_job();
    gbrt_in_t    j;
    int unsigned r, idx;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      j = make_job(ACT_W'($urandom_range(0, 3)), RPT_W'($urandom),
                   TPB_W'($urandom_range(0, 1024)), SPB_W'($urandom_range(0, 262144)),
                   CNT_W'($urandom));
    end else if (r < 45 && live_jobs.size() != 0) begin
      idx = $urandom_range(0, live_jobs.size() - 1);
      j = live_jobs[idx];
      live_jobs.delete(idx);
      j.action = ACT_RELEASE;
    end else if (r < 85) begin
      j = random_shape();
      j.action = ACT_ACQUIRE;
      if (live_jobs.size() < 16) live_jobs.push_back(j);
    end else begin
      j = random_shape();
    end
    return j;
  endfunction

  task automatic offer_job(input gbrt_in_t job);
    gbrt_out_t res;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data  = job;
    do @(posedge clk); while (!in_ch.ready);
    account_job(job, res);
    due_reports.push_back(res);
    if (!feed_steady) begin
      if (burst_left == 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left = burst_left - 1;
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (due_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_total(input gbrt_cfg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    case (idx)
      CFG_TOTAL_REGS: begin
        tot_regs  = value[REGS_W-1:0];
        free_regs = tot_regs;
      end
      CFG_TOTAL_SMEM: begin
        tot_smem  = value[SMEM_W-1:0];
        free_smem = tot_smem;
      end
      CFG_TOTAL_THREADS: begin
        tot_thr  = value[THR_W-1:0];
        free_thr = tot_thr;
      end
      CFG_TOTAL_BLOCKS: begin
        tot_blks  = value[BLK_W-1:0];
        free_blks = tot_blks;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_totals(input logic [CFG_DATA_W-1:0] regs,
                             input logic [CFG_DATA_W-1:0] smem,
                             input logic [CFG_DATA_W-1:0] thr,
                             input logic [CFG_DATA_W-1:0] blks);
    wait_drained();
    set_total(CFG_TOTAL_REGS, regs);
    set_total(CFG_TOTAL_SMEM, smem);
    set_total(CFG_TOTAL_THREADS, thr);
    set_total(CFG_TOTAL_BLOCKS, blks);
    live_jobs.delete();
  endtask

  task automatic test_default_query();
    offer_job(make_job(ACT_QUERY, '0, '0, '0, '0));
    offer_job(make_job(ACT_SPARE, 8'd1, 11'd32, 19'd1024, 12'd5));
  endtask

  task automatic test_saturating_counts();
    offer_job(make_job(ACT_ACQUIRE, 8'd255, 11'd1024, 19'd262144, 12'd4095));
    offer_job(make_job(ACT_QUERY, 8'd1, 11'd1, 19'd1, 12'd0));
    offer_job(make_job(ACT_RELEASE, 8'd255, 11'd1024, 19'd262144, 12'd4095));
    offer_job(make_job(ACT_ACQUIRE, 8'd32, 11'd256, 19'd4096, 12'd4));
    offer_job(make_job(ACT_RELEASE, 8'd32, 11'd256, 19'd4096, 12'd0));
    offer_job(make_job(ACT_ACQUIRE, 8'd0, 11'd1024, 19'd0, 12'd0));
    offer_job(make_job(ACT_ACQUIRE, 8'd0, 11'd0, 19'd0, 12'd31));
  endtask

  task automatic test_dot_saturation();
    load_totals(CFG_DATA_W'({REGS_W{1'b1}}), CFG_DATA_W'({SMEM_W{1'b1}}),
                CFG_DATA_W'({THR_W{1'b1}}), CFG_DATA_W'({BLK_W{1'b1}}));
    offer_job(make_job(ACT_QUERY, 8'd255, 11'd1024, 19'd262144, 12'd0));
    offer_job(make_job(ACT_ACQUIRE, 8'd255, 11'd1024, 19'd262144, 12'd1));
    offer_job(make_job(ACT_QUERY, '0, '0, '0, '0));
  endtask

  task automatic test_zero_totals();
    load_totals('0, '0, '0, '0);
    offer_job(make_job(ACT_QUERY, 8'd8, 11'd64, 19'd1024, 12'd1));
    offer_job(make_job(ACT_RELEASE, 8'd8, 11'd64, 19'd1024, 12'd5));
    offer_job(make_job(ACT_ACQUIRE, 8'd8, 11'd64, 19'd1024, 12'd5));
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: load_totals(CFG_DATA_W'(TOTAL_REGS_RST), CFG_DATA_W'(TOTAL_SMEM_RST),
                       CFG_DATA_W'(TOTAL_THR_RST), CFG_DATA_W'(TOTAL_BLK_RST));
        1: load_totals(CFG_DATA_W'($urandom_range(1, 4096)), CFG_DATA_W'($urandom_range(1, 8192)),
                       CFG_DATA_W'($urandom_range(1, 512)), CFG_DATA_W'($urandom_range(1, 16)));
        2: load_totals(CFG_DATA_W'({REGS_W{1'b1}}), CFG_DATA_W'({SMEM_W{1'b1}}),
                       CFG_DATA_W'({THR_W{1'b1}}), CFG_DATA_W'({BLK_W{1'b1}}));
        3: load_totals(CFG_DATA_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(1));
        default: begin
          load_totals(CFG_DATA_W'($urandom_range(1, 2**24 - 1)),
                      CFG_DATA_W'($urandom_range(1, 2**28 - 1)),
                      CFG_DATA_W'($urandom_range(1, 2**20 - 1)),
                      CFG_DATA_W'($urandom_range(1, 2**16 - 1)));
        end
      endcase
      feed_steady = (p % 3 == 1);
      rx_eager    = (p % 4 == 2);
      repeat (PHASE_ITEMS) offer_job(next_random_job());
    end
    feed_steady = 1'b0;
    rx_eager    = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering, then a full pause
  task automatic test_result_backlog();
    wait_drained();
    @(posedge clk);
    hold_reqs   = hold_reqs + 1;
    feed_steady = 1'b1;
    repeat (20) offer_job(next_random_job());
    wait_drained();
    feed_steady = 1'b0;
    repeat (10) offer_job(next_random_job());
  endtask

  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      rx_hold   = RX_HOLD_CYCLES;
    end
    if (rx_hold != 0) begin
      out_ch.ready = 1'b0;
      rx_hold = rx_hold - 1;
    end else if (rx_eager) begin
      out_ch.ready = 1'b1;
    end else begin
      out_ch.ready = rx_pattern[0];
      rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
      rx_tick = rx_tick + 6'd1;
      if (rx_tick == 0) rx_pattern = 16'($urandom) | 16'h0001;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_reports.size() == 0) begin
        $display("%0t: result with none expected, actual fit %0d dot %0d occupancy %0d",
                 $time, out_ch.data.fit_blocks, out_ch.data.dot_score,
                 out_ch.data.occupancy);
        errors = errors + 1;
      end else begin
        want = due_reports.pop_front();
        if (out_ch.data.fit_blocks !== want.fit_blocks) begin
          $display("%0t: fit_blocks expected %0d, actual %0d",
                   $time, want.fit_blocks, out_ch.data.fit_blocks);
          errors = errors + 1;
        end
        if (out_ch.data.dot_score !== want.dot_score) begin
          $display("%0t: dot_score expected %0d, actual %0d",
                   $time, want.dot_score, out_ch.data.dot_score);
          errors = errors + 1;
        end
        if (out_ch.data.occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d, actual %0d",
                   $time, want.occupancy, out_ch.data.occupancy);
          errors = errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles = stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, stuck_cycles, due_reports.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_TOTAL_REGS;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    tot_regs     = TOTAL_REGS_RST;
    tot_smem     = TOTAL_SMEM_RST;
    tot_thr      = TOTAL_THR_RST;
    tot_blks     = TOTAL_BLK_RST;
    free_regs    = tot_regs;
    free_smem    = tot_smem;
    free_thr     = tot_thr;
    free_blks    = tot_blks;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_default_query();
    test_saturating_counts();
    test_dot_saturation();
    test_zero_totals();
    test_random_phases();
    test_result_backlog();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
